>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions sampled on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/hcp_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code packer package
// Shared types and constants of the code packer and its code table.
// ----------------------------------------------------------------------------
package hcp_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned CODE_BITS     = 32;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned TABLE_DEPTH   = 256;
  localparam int unsigned OUT_BITS      = 32;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } hcp_cmd_e;

  typedef struct packed {
    logic [LEN_W-1:0]     len;
    logic [CODE_BITS-1:0] bits;
  } hcp_entry_t;

endpackage

>>> rtl/core/hcp_code_table.sv
// ----------------------------------------------------------------------------
// Huffman code table
// 256-entry code memory with one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module hcp_code_table import hcp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [SYM_W-1:0] wr_addr_i,
  input  hcp_entry_t       wr_entry_i,
  input  logic             rd_en_i,
  input  logic [SYM_W-1:0] rd_addr_i,
  output hcp_entry_t       rd_entry_o
);

  hcp_entry_t             mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  hcp_entry_t             rd_data_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;

endmodule

>>> rtl/core/huffman_code_packer_unit.sv
// Each code passes the table read register, then the output register, and
// out_stall_i can hold it between them. Throughput: one item per cycle while
// in_stall_o is low, set by the single code table read port and the shift-merge
// into the accumulator. Reset clears the table valid bits, the accumulator and
// the fill count at once; the block accepts items as soon as reset is released.
// ----------------------------------------------------------------------------
// Huffman code packer
// Looks up codes in the table and packs them LSB first into output words.
// ----------------------------------------------------------------------------
module huffman_code_packer_unit import hcp_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [SYM_W-1:0]     symbol_i,
  input  logic [LEN_W-1:0]     code_length_i,
  input  logic [CODE_BITS-1:0] code_bits_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_BITS-1:0]  packed_word_o,
  output logic [LEN_W-1:0]     valid_bits_o
);

  localparam int unsigned AW      = WORD_BITS + CODE_BITS;
  localparam int unsigned LEN_MAX = (WORD_BITS < CODE_BITS) ? WORD_BITS : CODE_BITS;
  localparam logic [LEN_W-1:0] LEN_SAT  = LEN_W'(LEN_MAX);
  localparam logic [LEN_W-1:0] FULL_CNT = LEN_W'(WORD_BITS);
  localparam logic [LEN_W:0]   WORD_CNT = (LEN_W + 1)'(WORD_BITS);

  hcp_cmd_e             cmd;
  logic                 accept;
  logic                 out_free;
  logic                 fire;
  hcp_entry_t           wr_entry;
  hcp_entry_t           rd_entry;
  logic [LEN_W-1:0]     len_sat;
  logic [CODE_BITS:0]   keep_w;

  logic                 s1_valid_q;
  logic                 s1_flush_q;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [LEN_W-1:0]     fill_q, fill_d;

  logic [AW-1:0]        shifted;
  logic [AW-1:0]        carry_w;
  logic [WORD_BITS-1:0] merged;
  logic [LEN_W:0]       total;
  logic                 emit;
  logic [WORD_BITS-1:0] res_word;
  logic [LEN_W-1:0]     res_cnt;
  logic [AW-1:0]        res_wide;

  logic                 out_valid_q;
  logic [OUT_BITS-1:0]  packed_word_q;
  logic [LEN_W-1:0]     valid_bits_q;

  assign cmd        = hcp_cmd_e'(cmd_i);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && out_free;

  assign len_sat       = (code_length_i > LEN_SAT) ? LEN_SAT : code_length_i;
  assign keep_w        = ((CODE_BITS + 1)'(1) << len_sat) - (CODE_BITS + 1)'(1);
  assign wr_entry.len  = len_sat;
  assign wr_entry.bits = code_bits_i & keep_w[CODE_BITS-1:0];

  hcp_code_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept && (cmd == CMD_LOAD)),
    .wr_addr_i  (symbol_i),
    .wr_entry_i (wr_entry),
    .rd_en_i    (accept && (cmd == CMD_ENCODE)),
    .rd_addr_i  (symbol_i),
    .rd_entry_o (rd_entry)
  );

  assign shifted = AW'(rd_entry.bits) << fill_q;
  assign carry_w = shifted >> WORD_BITS;
  assign merged  = acc_q | shifted[WORD_BITS-1:0];
  assign total   = {1'b0, fill_q} + {1'b0, rd_entry.len};

  always_comb begin
    acc_d    = acc_q;
    fill_d   = fill_q;
    emit     = 1'b0;
    res_word = merged;
    res_cnt  = FULL_CNT;
    if (s1_flush_q) begin
      if (fill_q != '0) begin
        emit     = 1'b1;
        res_word = acc_q;
        res_cnt  = fill_q;
        acc_d    = '0;
        fill_d   = '0;
      end
    end else if (rd_entry.len != '0) begin
      if (total >= WORD_CNT) begin
        emit   = 1'b1;
        acc_d  = carry_w[WORD_BITS-1:0];
        fill_d = LEN_W'(total - WORD_CNT);
      end else begin
        acc_d  = merged;
        fill_d = total[LEN_W-1:0];
      end
    end
  end

  assign res_wide = AW'(res_word);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_flush_q  <= 1'b0;
      acc_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= accept && ((cmd == CMD_ENCODE) || (cmd == CMD_FLUSH));
        s1_flush_q <= cmd == CMD_FLUSH;
      end
      if (fire) begin
        acc_q  <= acc_d;
        fill_q <= fill_d;
      end
      if (out_free) begin
        out_valid_q <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      packed_word_q <= res_wide[OUT_BITS-1:0];
      valid_bits_q  <= res_cnt;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_word_o = packed_word_q;
  assign valid_bits_o  = valid_bits_q;

endmodule

>>> rtl/core/hcp_checker.sv
// ----------------------------------------------------------------------------
// Huffman code packer checker
// Port-level assertions on the output channel, bound to huffman_code_packer_unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcp_checker import hcp_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [OUT_BITS-1:0]  packed_word_o,
  input logic [LEN_W-1:0]     valid_bits_o
);

  `ASSERT_ALWAYS(a_no_item_in_reset, (!rst_ni |=> !out_valid_o), "item shown during reset")

  `ASSERT_CLK(a_valid_holds, (out_valid_o && out_stall_i |=> out_valid_o), "valid dropped")

  `ASSERT_CLK(a_data_holds,
              (out_valid_o && out_stall_i |=> $stable(packed_word_o) && $stable(valid_bits_o)),
              "payload changed")

  `ASSERT_CLK(a_count_range,
              (out_valid_o |-> (valid_bits_o != '0 || WORD_BITS == 64) &&
                               (32'(valid_bits_o) <= WORD_BITS)),
              "bad bit count")

  `ASSERT_CLK(a_upper_clear,
              (out_valid_o && valid_bits_o != '0 && valid_bits_o < 6'd32 |->
               (packed_word_o >> valid_bits_o) == '0),
              "bits set above count")

endmodule

bind huffman_code_packer_unit hcp_checker #(.WORD_BITS(WORD_BITS)) u_hcp_checker (.*);

>>> tb/tb_huffman_code_packer_unit.sv
// ----------------------------------------------------------------------------
// Testbench of the Huffman code packer
// Loads code table entries, encodes symbol streams and flushes partial words.
// Every output word is compared with a cycle-free model of the packer, while
// both handshake sides idle at random and the receiver once holds off long.
// ----------------------------------------------------------------------------
module tb_huffman_code_packer_unit import hcp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNDEF = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [OUT_BITS-1:0] word;
    logic [LEN_W-1:0]    nbits;
  } packed_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           cmd_i = CMD_LOAD;
  logic [SYM_W-1:0]     symbol_i = '0;
  logic [LEN_W-1:0]     code_length_i = '0;
  logic [CODE_BITS-1:0] code_bits_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [OUT_BITS-1:0]  packed_word_o;
  logic [LEN_W-1:0]     valid_bits_o;

  logic [LEN_W-1:0]     code_len_tbl [TABLE_DEPTH];
  logic [CODE_BITS-1:0] code_bits_tbl [TABLE_DEPTH];
  logic [OUT_BITS-1:0]  pending_bits;
  logic [LEN_W-1:0]     pending_count;
  packed_word_t         expected_words [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_off = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  huffman_code_packer_unit i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .cmd_i,
    .symbol_i,
    .code_length_i,
    .code_bits_i,
    .out_valid_o,
    .out_stall_i,
    .packed_word_o,
    .valid_bits_o
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    packed_word_t exp_word;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word %h with %0d valid bits", packed_word_o, valid_bits_o);
        error_count++;
      end else begin
        exp_word = expected_words.pop_front();
        if (packed_word_o !== exp_word.word) begin
          $error("packed_word: expected %h, actual %h", exp_word.word, packed_word_o);
          error_count++;
        end
        if (valid_bits_o !== exp_word.nbits) begin
          $error("valid_bits: expected %0d, actual %0d", exp_word.nbits, valid_bits_o);
          error_count++;
        end
      end
    end
  end

  function automatic void clear_packer_model();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      code_len_tbl[i]  = '0;
      code_bits_tbl[i] = '0;
    end
    pending_bits  = '0;
    pending_count = '0;
  endfunction

  function automatic void predict_packed_word(input logic [1:0] cmd,
                                              input logic [SYM_W-1:0] sym,
                                              input logic [LEN_W-1:0] len_in,
                                              input logic [CODE_BITS-1:0] bits_in);
    logic [LEN_W-1:0]     len;
    logic [CODE_BITS-1:0] keep;
    logic [63:0]          code;
    logic [6:0]           total;
    logic [OUT_BITS-1:0]  merged;
    case (cmd)
      CMD_LOAD: begin
        len  = (len_in > LEN_W'(CODE_BITS)) ? LEN_W'(CODE_BITS) : len_in;
        keep = (len >= LEN_W'(CODE_BITS)) ? '1 : ((CODE_BITS'(1) << len) - 1'b1);
        code_len_tbl[sym]  = len;
        code_bits_tbl[sym] = bits_in & keep;
      end
      CMD_ENCODE: begin
        if (code_len_tbl[sym] != 0) begin
          code   = 64'(code_bits_tbl[sym]);
          total  = 7'(pending_count) + 7'(code_len_tbl[sym]);
          merged = pending_bits | OUT_BITS'(code << pending_count);
          if (total >= 7'(OUT_BITS)) begin
            expected_words.push_back('{word: merged, nbits: LEN_W'(OUT_BITS)});
            pending_bits  = OUT_BITS'(code >> (OUT_BITS - pending_count));
            pending_count = LEN_W'(total - 7'(OUT_BITS));
          end else begin
            pending_bits  = merged;
            pending_count = LEN_W'(total);
          end
        end
      end
      CMD_FLUSH: begin
        if (pending_count != 0) begin
          expected_words.push_back('{word: pending_bits, nbits: pending_count});
          pending_bits  = '0;
          pending_count = '0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic [LEN_W-1:0] len, input logic [CODE_BITS-1:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    symbol_i      <= sym;
    code_length_i <= len;
    code_bits_i   <= bits;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_packed_word(cmd, sym, len, bits);
  endtask

  function automatic logic [LEN_W-1:0] random_code_length();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 10) return LEN_W'($urandom_range(63, 33));
    if (pick < 22) return LEN_W'($urandom_range(32, 13));
    return LEN_W'($urandom_range(12, 1));
  endfunction

  function automatic logic [SYM_W-1:0] random_used_symbol();
    logic [SYM_W-1:0] sym;
    sym = SYM_W'($urandom_range(255));
    for (int i = 0; i < 6 && code_len_tbl[sym] == 0; i++) begin
      sym = SYM_W'($urandom_range(255));
    end
    return sym;
  endfunction

  // Right after reset every symbol is unused and nothing is pending.
  task automatic test_unused_and_empty();
    send_item(CMD_ENCODE, 8'd0, '0, '0);
    send_item(CMD_FLUSH, 8'd255, '1, '1);
    send_item(CMD_UNDEF, 8'hFF, '1, '1);
    send_item(CMD_ENCODE, 8'd255, '1, '1);
  endtask

  task automatic test_table_load_extremes();
    send_item(CMD_LOAD, 8'd0, 6'd0, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 8'd255, 6'd32, 32'hA5A5_5A5A);
    send_item(CMD_LOAD, 8'd1, 6'd1, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 8'd2, 6'd63, 32'h1234_5678);
    send_item(CMD_LOAD, 8'd3, 6'd33, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 8'd4, 6'd5, 32'hFFFF_FFE0);
    send_item(CMD_LOAD, 8'd5, 6'd7, 32'h0000_0055);
  endtask

  task automatic test_packing_edges();
    send_item(CMD_ENCODE, 8'd255, '0, '0);
    send_item(CMD_ENCODE, 8'd1, '0, '0);
    send_item(CMD_ENCODE, 8'd2, '0, '0);
    send_item(CMD_FLUSH, 8'd0, '0, '0);
    send_item(CMD_ENCODE, 8'd0, '0, '0);
    repeat (3) send_item(CMD_ENCODE, 8'd4, '0, '0);
    send_item(CMD_ENCODE, 8'd5, '0, '0);
    send_item(CMD_ENCODE, 8'd3, '0, '0);
    send_item(CMD_FLUSH, 8'd0, '0, '0);
    send_item(CMD_FLUSH, 8'd0, '0, '0);
  endtask

  // Mostly encodes of loaded symbols, with table updates, flushes and noise.
  task automatic test_random_stream(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_item(CMD_LOAD, SYM_W'($urandom_range(255)), random_code_length(), $urandom());
        sent++;
      end else if (pick < 88) begin
        send_item(CMD_ENCODE, random_used_symbol(), LEN_W'($urandom_range(63)), $urandom());
        sent++;
      end else if (pick < 96) begin
        send_item(CMD_FLUSH, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(63)),
                  $urandom());
        sent++;
      end else begin
        send_item(CMD_UNDEF, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(63)),
                  $urandom());
      end
    end
  endtask

  // The receiver stops for a long stretch so that the block fills up.
  task automatic test_output_backpressure();
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      begin
        for (int i = 0; i < 150; i++) begin
          send_item(CMD_ENCODE, random_used_symbol(), '0, '0);
        end
      end
    join
  endtask

  initial begin
    clear_packer_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 11;
    recv_idle_pct = 70;
    test_unused_and_empty();
    test_table_load_extremes();
    test_packing_edges();
    for (int i = 0; i < 48; i++) begin
      send_item(CMD_LOAD, SYM_W'($urandom_range(255)), random_code_length(), $urandom());
    end
    test_random_stream(400);

    send_idle_pct = 70;
    recv_idle_pct = 11;
    test_random_stream(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(350);
    test_output_backpressure();
    send_item(CMD_FLUSH, 8'd0, '0, '0);

    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/hcp_pkg.sv
rtl/core/hcp_code_table.sv
rtl/core/huffman_code_packer_unit.sv
rtl/core/hcp_checker.sv
tb/tb_huffman_code_packer_unit.sv
